/* rtl/core/fbbc_pkg.sv */
package fbbc_pkg;

    localparam int CFG_BITS        = 11;
    localparam int OUT_BITS        = 16;
    localparam int FRAME_WIDTH_RST = 512;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // divisor of a clipped window: rows * cols
    typedef enum logic [2:0] {
        DIV1 = 3'd0,
        DIV2 = 3'd1,
        DIV3 = 3'd2,
        DIV4 = 3'd3,
        DIV6 = 3'd4,
        DIV9 = 3'd5
    } t_div;

    typedef struct packed {
        logic [1:0] rows;
        logic [1:0] cols;
        logic       done;
    } t_win_ctl;

    function automatic t_div div_code(input logic [1:0] rows, input logic [1:0] cols);
        t_div d;
        unique case ({rows, cols}) inside
            4'b01_01:           d = DIV1;
            4'b01_10, 4'b10_01: d = DIV2;
            4'b01_11, 4'b11_01: d = DIV3;
            4'b10_10:           d = DIV4;
            4'b10_11, 4'b11_10: d = DIV6;
            4'b11_11:           d = DIV9;
            default:            d = DIV1;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/forward_box_blur_3x3_clipped.sv */
// Forward 3x3 box blur, clipped at the right and bottom frame edges.
// Input channel (i_in_valid / o_in_ready): one request per pixel in raster
// order, i_opcode 0 for a pixel, 1 for a drain request after the frame.
// A drain request while frame pixels are still due is dropped; a pixel
// request after the last pixel acts as a drain request.
// Output channel (o_out_valid / i_out_ready): the mean of the window at each
// position, o_frame_done on the bottom right one. The window for position p
// completes on request p + 2*width + 2; its mean passes stages 1-3 and the
// output register. One request per cycle is sustained unless the receiver
// stalls; the two line stores set the rate, each read at the request's column
// on acceptance, written as it leaves stage 1, forwarded for a one-pixel frame.
// Config channel (i_cfg_valid / o_cfg_ready): writes frame_width (0 is taken
// as 1, large values as MAX_WIDTH) and restarts the frame. Write only when
// the block is idle.
// Reset (synchronous, active low) sets width 512 and restarts the frame; the
// line stores are not cleared, as a mean only ever uses store entries written
// in the current frame. When the receiver stalls, the output register holds
// and the four-stage pipeline fills up before o_in_ready drops.
module forward_box_blur_3x3_clipped
    import fbbc_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [15:0]         i_in_red,
    input  logic [15:0]         i_in_green,
    input  logic [15:0]         i_in_blue,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_BITS-1:0] o_out_red,
    output logic [OUT_BITS-1:0] o_out_green,
    output logic [OUT_BITS-1:0] o_out_blue,
    output logic                o_frame_done
);

    localparam int PB      = $clog2(MAX_WIDTH);
    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int CB      = $clog2(MAX_WIDTH * MAX_WIDTH + 2 * MAX_WIDTH + 3);
    localparam int CHB     = CHANNEL_BITS;
    localparam int PXB     = 3 * CHB;
    localparam int SB      = CHB + 4;
    localparam int SH      = SB + 4;
    localparam int MB      = SH + 1;
    localparam int PRB     = SB + MB;
    localparam int RESET_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;

    // ceil(2^SH / d): exact floor division for sums below 2^SB
    localparam logic [MB-1:0] M1 = MB'(1 << SH);
    localparam logic [MB-1:0] M2 = MB'(((1 << SH) + 1) / 2);
    localparam logic [MB-1:0] M3 = MB'(((1 << SH) + 2) / 3);
    localparam logic [MB-1:0] M4 = MB'(((1 << SH) + 3) / 4);
    localparam logic [MB-1:0] M6 = MB'(((1 << SH) + 5) / 6);
    localparam logic [MB-1:0] M9 = MB'(((1 << SH) + 8) / 9);

    // frame control
    logic [WB-1:0]  r_w;
    logic [CB-1:0]  r_total;
    logic [CB-1:0]  r_lag;
    logic [CB-1:0]  r_cnt;
    logic [PB-1:0]  r_col;
    logic [PB-1:0]  r_out_row;
    logic [PB-1:0]  r_out_col;
    logic [WB-1:0]  n_w;

    logic           cfg_wr;
    logic           in_acc;
    logic           in_frame;
    logic           take;
    logic           has_res;
    logic           done_now;
    logic [WB-1:0]  row_left;
    logic [WB-1:0]  col_left;
    logic [1:0]     rows_now;
    logic [1:0]     cols_now;
    logic [PXB-1:0] px_in;

    // pipeline
    logic           r_s1_v;
    logic [PXB-1:0] r_s1_px;
    logic [PB-1:0]  r_s1_col;
    logic           r_s1_res;
    t_win_ctl       r_s1_ctl;

    logic [PXB-1:0] mem_old [MAX_WIDTH];
    logic [PXB-1:0] mem_new [MAX_WIDTH];
    logic [PXB-1:0] r_old_q;
    logic [PXB-1:0] r_new_q;
    logic           r_byp;
    logic [PXB-1:0] r_byp_old;
    logic [PXB-1:0] r_byp_new;
    logic [PXB-1:0] rd_old;
    logic [PXB-1:0] rd_new;

    logic [PXB-1:0] r_win [9];
    logic           r_s2_v;
    t_win_ctl       r_s2_ctl;
    logic [SB-1:0]  sum [3];

    logic           r_s3_v;
    logic [SB-1:0]  r_s3_sum [3];
    t_div           r_s3_div;
    logic           r_s3_done;
    logic [MB-1:0]  mult;
    logic [PRB-1:0] prod [3];

    logic           r_out_v;
    logic [OUT_BITS-1:0] r_out_ch [3];
    logic           r_out_done;

    logic           out_free;
    logic           s3_ready;
    logic           s2_ready;
    logic           s1_adv;
    logic           s2_adv;
    logic           s3_adv;

    assign out_free   = !r_out_v || i_out_ready;
    assign s3_adv     = r_s3_v && out_free;
    assign s3_ready   = !r_s3_v || out_free;
    assign s2_adv     = r_s2_v && s3_ready;
    assign s2_ready   = !r_s2_v || s3_ready;
    assign s1_adv     = r_s1_v && s2_ready;
    assign o_in_ready = !r_s1_v || s2_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_w = WB'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            n_w = WB'(MAX_WIDTH);
        end else begin
            n_w = WB'(i_cfg_data);
        end
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_frame = r_cnt < r_total;
    assign take     = in_acc && !((i_opcode == OP_DRAIN) && in_frame);
    assign has_res  = r_cnt >= r_lag;
    assign row_left = r_w - WB'(r_out_row);
    assign col_left = r_w - WB'(r_out_col);
    assign rows_now = (row_left >= WB'(3)) ? 2'd3 : row_left[1:0];
    assign cols_now = (col_left >= WB'(3)) ? 2'd3 : col_left[1:0];
    assign done_now = (WB'(r_out_row) == r_w - WB'(1)) && (WB'(r_out_col) == r_w - WB'(1));
    assign px_in    = in_frame ? {i_in_red[CHB-1:0], i_in_green[CHB-1:0], i_in_blue[CHB-1:0]}
                               : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WB'(RESET_W);
            r_total   <= CB'(RESET_W * RESET_W);
            r_lag     <= CB'(2 * RESET_W + 2);
            r_cnt     <= '0;
            r_col     <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (cfg_wr) begin
            r_w       <= n_w;
            r_total   <= CB'(n_w) * CB'(n_w);
            r_lag     <= CB'(n_w) + CB'(n_w) + CB'(2);
            r_cnt     <= '0;
            r_col     <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (take) begin
            if (has_res && done_now) begin
                r_cnt     <= '0;
                r_col     <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                r_cnt <= r_cnt + CB'(1);
                r_col <= (WB'(r_col) == r_w - WB'(1)) ? '0 : r_col + PB'(1);
                if (has_res) begin
                    if (WB'(r_out_col) == r_w - WB'(1)) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + PB'(1);
                    end else begin
                        r_out_col <= r_out_col + PB'(1);
                    end
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (take) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_v <= r_s1_res;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_v <= 1'b1;
            end else if (s3_adv) begin
                r_s3_v <= 1'b0;
            end
            if (s3_adv) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // stage 1: request captured, line stores read at its column
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_px       <= px_in;
            r_s1_col      <= r_col;
            r_s1_res      <= has_res;
            r_s1_ctl.rows <= rows_now;
            r_s1_ctl.cols <= cols_now;
            r_s1_ctl.done <= done_now;
        end
    end

    // same column read while the previous request writes it: one-pixel frame
    assign rd_old = r_byp ? r_byp_old : r_old_q;
    assign rd_new = r_byp ? r_byp_new : r_new_q;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_old_q   <= mem_old[r_col];
            r_new_q   <= mem_new[r_col];
            r_byp     <= s1_adv && (r_s1_col == r_col);
            r_byp_old <= rd_new;
            r_byp_new <= r_s1_px;
        end
        if (s1_adv) begin
            mem_old[r_s1_col] <= rd_new;
            mem_new[r_s1_col] <= r_s1_px;
        end
    end

    // stage 2: window shift, one column of three rows a request
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k + 3];
            end
            r_win[6] <= rd_old;
            r_win[7] <= rd_new;
            r_win[8] <= r_s1_px;
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int cc = 0; cc < 3; cc++) begin
                for (int rr = 0; rr < 3; rr++) begin
                    if ((2'(cc) < r_s2_ctl.cols) && (2'(rr) < r_s2_ctl.rows)) begin
                        sum[ch] = sum[ch] + SB'(r_win[cc * 3 + rr][(2 - ch) * CHB +: CHB]);
                    end
                end
            end
        end
    end

    // stage 3: sums and divisor
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_s3_sum[ch] <= sum[ch];
            end
            r_s3_div  <= div_code(r_s2_ctl.rows, r_s2_ctl.cols);
            r_s3_done <= r_s2_ctl.done;
        end
    end

    always_comb begin
        unique case (r_s3_div)
            DIV1:    mult = M1;
            DIV2:    mult = M2;
            DIV3:    mult = M3;
            DIV4:    mult = M4;
            DIV6:    mult = M6;
            DIV9:    mult = M9;
            default: mult = M1;
        endcase
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PRB'(r_s3_sum[ch]) * PRB'(mult);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_ch[ch] <= OUT_BITS'(prod[ch][SH +: CHB]);
            end
            r_out_done <= r_s3_done;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_out_red    = r_out_ch[0];
    assign o_out_green  = r_out_ch[1];
    assign o_out_blue   = r_out_ch[2];
    assign o_frame_done = r_out_done;

    // bottom right result restarts the frame
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && has_res && done_now && !cfg_wr)
        |=> (r_cnt == '0 && r_col == '0 && r_out_row == '0 && r_out_col == '0))
        else $error("frame did not restart after bottom right result");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WB'(r_col) < r_w) && (WB'(r_out_row) < r_w) && (WB'(r_out_col) < r_w))
        else $error("column or result position beyond frame width");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_adv && r_s3_done) |=> (o_out_valid && o_frame_done))
        else $error("frame done flag lost on its way to the output");

endmodule
